[design/bls_pkg.sv]
package bls_pkg;

	// default coordinate width
	localparam int COORD_BITS_DEF = 10;

	// input item kinds
	localparam logic KIND_START = 1'b0;
	localparam logic KIND_STEP  = 1'b1;

	// result handed from the stepping core to the output stage
	typedef struct packed {
		logic valid;
		logic last;
	} bls_res_ctl_t;

endpackage

[design/bls_step_core.sv]
module bls_step_core #(
	parameter int COORD_BITS = bls_pkg::COORD_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    load,
	input  logic                    step,
	input  logic [COORD_BITS-1:0]   x_start,
	input  logic [COORD_BITS-1:0]   y_start,
	input  logic [COORD_BITS-1:0]   x_end,
	input  logic [COORD_BITS-1:0]   y_end,
	output bls_pkg::bls_res_ctl_t   res_ctl,
	output logic [COORD_BITS-1:0]   res_x,
	output logic [COORD_BITS-1:0]   res_y
);

	localparam int DW = COORD_BITS + 3;

	logic [COORD_BITS-1:0] cur_x_q, cur_y_q, goal_x_q, goal_y_q;
	logic [COORD_BITS-1:0] delta_x_q, delta_y_q;
	logic                  step_neg_x_q, step_neg_y_q, y_major_q, active_q;
	logic signed [DW-1:0]  decision_q;

	// start-item setup values
	logic                  ld_neg_x, ld_neg_y, ld_y_major;
	logic [COORD_BITS-1:0] ld_dx, ld_dy, ld_major, ld_minor;
	logic signed [DW-1:0]  ld_decision;

	// step-item values
	logic                  done;
	logic                  dec_ge;
	logic [COORD_BITS-1:0] major, minor;
	logic signed [DW-1:0]  nxt_decision;
	logic [COORD_BITS-1:0] inc_x, inc_y;

	// work out deltas, directions, major axis and initial decision term
	always_comb begin
		ld_neg_x    = x_end < x_start;
		ld_neg_y    = y_end < y_start;
		ld_dx       = ld_neg_x ? (x_start - x_end) : (x_end - x_start);
		ld_dy       = ld_neg_y ? (y_start - y_end) : (y_end - y_start);
		ld_y_major  = ld_dy > ld_dx;
		ld_major    = ld_y_major ? ld_dy : ld_dx;
		ld_minor    = ld_y_major ? ld_dx : ld_dy;
		ld_decision = $signed({2'b00, ld_minor, 1'b0}) - $signed({3'b000, ld_major});
	end

	// advance one pixel along the major axis, minor when decision is non-negative
	always_comb begin
		done         = y_major_q ? (cur_y_q == goal_y_q) : (cur_x_q == goal_x_q);
		major        = y_major_q ? delta_y_q : delta_x_q;
		minor        = y_major_q ? delta_x_q : delta_y_q;
		dec_ge       = ~decision_q[DW-1];
		nxt_decision = decision_q + $signed({2'b00, minor, 1'b0})
			- (dec_ge ? $signed({2'b00, major, 1'b0}) : $signed({DW{1'b0}}));
		inc_x        = step_neg_x_q ? (cur_x_q - 1'b1) : (cur_x_q + 1'b1);
		inc_y        = step_neg_y_q ? (cur_y_q - 1'b1) : (cur_y_q + 1'b1);
	end

	// load a new line or advance the current one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q      <= '0;
			cur_y_q      <= '0;
			goal_x_q     <= '0;
			goal_y_q     <= '0;
			delta_x_q    <= '0;
			delta_y_q    <= '0;
			step_neg_x_q <= 1'b0;
			step_neg_y_q <= 1'b0;
			y_major_q    <= 1'b0;
			active_q     <= 1'b0;
			decision_q   <= '0;
		end else if (load) begin
			cur_x_q      <= x_start;
			cur_y_q      <= y_start;
			goal_x_q     <= x_end;
			goal_y_q     <= y_end;
			delta_x_q    <= ld_dx;
			delta_y_q    <= ld_dy;
			step_neg_x_q <= ld_neg_x;
			step_neg_y_q <= ld_neg_y;
			y_major_q    <= ld_y_major;
			active_q     <= 1'b1;
			decision_q   <= ld_decision;
		end else if (step && active_q) begin
			if (done) begin
				active_q <= 1'b0;
			end else begin
				decision_q <= nxt_decision;
				if (y_major_q) begin
					cur_y_q <= inc_y;
					if (dec_ge) begin
						cur_x_q <= inc_x;
					end
				end else begin
					cur_x_q <= inc_x;
					if (dec_ge) begin
						cur_y_q <= inc_y;
					end
				end
			end
		end
	end

	// emit the current pixel on a step with an active line
	assign res_ctl.valid = step && active_q;
	assign res_ctl.last  = done;
	assign res_x         = cur_x_q;
	assign res_y         = cur_y_q;

endmodule

[design/bresenham_line_stepper.sv]
// Bresenham line stepper, all eight octants.
// A step item's pixel is registered into the output register, or into skid when stalled.
// One item per cycle while in_ready is high; a start item gives no pixel.
// A two-entry output buffer (output register plus skid) keeps input open for one stall.
// Reset (arst_n low, asynchronous): no line loaded, output buffer empty.
module bresenham_line_stepper #(
	parameter int COORD_BITS = bls_pkg::COORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  kind,
	input  logic [COORD_BITS-1:0] x_start,
	input  logic [COORD_BITS-1:0] y_start,
	input  logic [COORD_BITS-1:0] x_end,
	input  logic [COORD_BITS-1:0] y_end,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [COORD_BITS-1:0] pixel_x,
	output logic [COORD_BITS-1:0] pixel_y,
	output logic                  last
);

	logic                  accept;
	bls_pkg::bls_res_ctl_t res_ctl;
	logic [COORD_BITS-1:0] res_x, res_y;

	logic                  out_valid_q, skid_valid_q;
	logic [COORD_BITS-1:0] out_x_q, out_y_q, skid_x_q, skid_y_q;
	logic                  out_last_q, skid_last_q;

	assign in_ready = ~skid_valid_q;
	assign accept   = in_valid && in_ready;

	bls_step_core #(
		.COORD_BITS(COORD_BITS)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (accept && (kind == bls_pkg::KIND_START)),
		.step    (accept && (kind == bls_pkg::KIND_STEP)),
		.x_start (x_start),
		.y_start (y_start),
		.x_end   (x_end),
		.y_end   (y_end),
		.res_ctl (res_ctl),
		.res_x   (res_x),
		.res_y   (res_y)
	);

	// hold results in the output register, spill into skid when stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_valid_q && !out_ready) begin
			if (res_ctl.valid) begin
				skid_valid_q <= 1'b1;
			end
		end else if (skid_valid_q) begin
			out_valid_q  <= 1'b1;
			skid_valid_q <= 1'b0;
		end else begin
			out_valid_q <= res_ctl.valid;
		end
	end

	// move payload alongside the valid bits
	always_ff @(posedge clk) begin
		if (out_valid_q && !out_ready) begin
			if (res_ctl.valid) begin
				skid_x_q    <= res_x;
				skid_y_q    <= res_y;
				skid_last_q <= res_ctl.last;
			end
		end else if (skid_valid_q) begin
			out_x_q    <= skid_x_q;
			out_y_q    <= skid_y_q;
			out_last_q <= skid_last_q;
		end else if (res_ctl.valid) begin
			out_x_q    <= res_x;
			out_y_q    <= res_y;
			out_last_q <= res_ctl.last;
		end
	end

	assign out_valid = out_valid_q;
	assign pixel_x   = out_x_q;
	assign pixel_y   = out_y_q;
	assign last      = out_last_q;

endmodule
